[sv/phbs_pkg.sv]
// Shared types and constants of the polynomial hash bucket set.
package phbs_pkg;
  localparam int MaxBuckets = 1024;
  localparam int SlotsPerBucket = 4;
  localparam int MaxKeyChars = 20;
  localparam int KeyWords = (MaxKeyChars + 7) / 8;
  localparam int BucketBits = $clog2(MaxBuckets);
  localparam int SlotBits = $clog2(SlotsPerBucket);
  localparam int FillBits = $clog2(SlotsPerBucket + 1);
  localparam int WordSelBits = $clog2(KeyWords);
  localparam int TotalSlots = MaxBuckets * SlotsPerBucket;
  localparam int TotalWords = TotalSlots * KeyWords;
  localparam int SlotAddrBits = $clog2(TotalSlots);
  localparam int WordAddrBits = $clog2(TotalWords);
  localparam int ByteCntBits = $clog2(MaxKeyChars + 1);

  localparam logic [1:0] StatusInserted = 2'd0;
  localparam logic [1:0] StatusHit = 2'd1;
  localparam logic [1:0] StatusMiss = 2'd2;
  localparam logic [1:0] StatusFull = 2'd3;

  localparam logic RegTableSize = 1'b0;
  localparam logic RegHashMultiplier = 1'b1;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_start;
    logic mod_step;
    logic fill_read;
    logic fill_write;
    logic slot_compare;
    logic key_write;
    logic done;
    logic clear_step;
  } phbs_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic mod_last;
    logic is_search;
    logic bucket_full;
    logic slot_last;
    logic word_last;
    logic matched;
    logic clear_last;
  } phbs_stat_t;
endpackage

[sv/phbs_ram.sv]
// Generic single-port RAM with registered read.
module phbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/phbs_ctrl.sv]
// Controller state machine for the hash bucket set.
module phbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  phbs_pkg::phbs_stat_t stat,
  output logic                busy,
  output phbs_pkg::phbs_cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HASH  = 11'b00000000100,
    S_MOD   = 11'b00000001000,
    S_FILLR = 11'b00000010000,
    S_FILLW = 11'b00000100000,
    S_DEC   = 11'b00001000000,
    S_WRITE = 11'b00010000000,
    S_RDREQ = 11'b00100000000,
    S_CMP   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_last) begin
          state_next = S_MOD;
          cmd.mod_start = 1'b1;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_FILLR;
        end
      end
      S_FILLR: begin
        cmd.fill_read = 1'b1;
        state_next = S_FILLW;
      end
      S_FILLW: begin
        state_next = S_DEC;
      end
      S_DEC: begin
        if (!stat.is_search) begin
          if (stat.bucket_full) begin
            state_next = S_DONE;
          end else begin
            cmd.fill_write = 1'b1;
            state_next = S_WRITE;
          end
        end else if (stat.slot_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RDREQ;
        end
      end
      S_WRITE: begin
        cmd.key_write = 1'b1;
        if (stat.word_last) begin
          state_next = S_DONE;
        end
      end
      S_RDREQ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.slot_compare = 1'b1;
        if (stat.matched) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DEC;
        end
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

[sv/phbs_datapath.sv]
// Datapath: Horner hash, iterative modulo, bucket fill and key slot stores.
module phbs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                kind,
  input  logic [63:0]         key_bytes_low,
  input  logic [63:0]         key_bytes_mid,
  input  logic [31:0]         key_bytes_high,
  input  logic [4:0]          key_length,
  input  phbs_pkg::phbs_cmd_t  cmd,
  output phbs_pkg::phbs_stat_t stat,
  output logic                done,
  output logic [1:0]          status,
  output logic [9:0]          bucket
);
  localparam int KeyBits = phbs_pkg::KeyWords * 64;

  logic [10:0] table_size;
  logic [31:0] hash_multiplier;
  logic        is_search;
  logic [KeyBits-1:0] key;
  logic [8*phbs_pkg::MaxKeyChars-1:0] key_in;
  logic [phbs_pkg::ByteCntBits-1:0] len;
  logic [phbs_pkg::ByteCntBits-1:0] pos;
  logic [31:0] hash;
  logic [10:0] divisor;
  logic [5:0]  mod_cnt;
  logic [phbs_pkg::BucketBits-1:0] bkt;
  logic [phbs_pkg::FillBits-1:0] fill;
  logic [phbs_pkg::FillBits-1:0] slot_idx;
  logic [phbs_pkg::WordSelBits-1:0] word_idx;
  logic        matched;
  logic        word_ok;
  logic [1:0]  status_reg;
  logic        done_reg;
  logic        fill_rd_pending;

  logic [phbs_pkg::BucketBits-1:0] clr_addr;
  logic [phbs_pkg::BucketBits-1:0] fill_addr;
  logic        fill_we;
  logic [phbs_pkg::FillBits-1:0] fill_wdata;
  logic [phbs_pkg::FillBits-1:0] fill_rdata;

  logic [4:0]  ln_in;
  logic [phbs_pkg::ByteCntBits-1:0] len_in;
  logic [7:0]  cur_byte;
  logic [63:0] prod;
  logic [10:0] eff_size;

  assign key_in = {key_bytes_high, key_bytes_mid, key_bytes_low};

  always_comb begin
    ln_in = key_length;
    if (ln_in == 5'd0) begin
      ln_in = 5'd1;
    end
    if (ln_in > 5'(phbs_pkg::MaxKeyChars)) begin
      ln_in = 5'(phbs_pkg::MaxKeyChars);
    end
    len_in = phbs_pkg::ByteCntBits'(ln_in);
  end

  always_comb begin
    eff_size = table_size;
    if (eff_size == 11'd0) begin
      eff_size = 11'd1;
    end
    if (eff_size > 11'(phbs_pkg::MaxBuckets)) begin
      eff_size = 11'(phbs_pkg::MaxBuckets);
    end
  end

  assign cur_byte = key[8*pos +: 8];
  assign prod = hash * hash_multiplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 11'd1024;
      hash_multiplier <= 32'd31;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phbs_pkg::RegTableSize: table_size <= cfg_data[10:0];
        phbs_pkg::RegHashMultiplier: hash_multiplier <= cfg_data;
        default: ;
      endcase
    end
  end

  // Key bytes beyond the length are cleared so stored words compare cleanly.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_search <= kind;
      len <= len_in;
      for (int i = 0; i < phbs_pkg::MaxKeyChars; i++) begin
        if (i < int'(len_in)) begin
          key[8*i +: 8] <= key_in[8*i +: 8];
        end else begin
          key[8*i +: 8] <= 8'd0;
        end
      end
      key[KeyBits-1:8*phbs_pkg::MaxKeyChars] <= '0;
      pos <= '0;
      hash <= '0;
    end else if (cmd.hash_step) begin
      hash <= prod[31:0] + {24'd0, cur_byte};
      pos <= pos + 1'b1;
    end
  end

  assign stat.hash_last = (pos + 1'b1 == len);

  // Restoring division, one quotient bit per cycle; hash uses the step result.
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      divisor <= eff_size;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt <= mod_cnt + 1'b1;
    end
  end

  logic [31:0] rwork;
  logic [10:0] part;
  logic [11:0] diff;
  assign diff = {part, rwork[31]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      rwork <= prod[31:0] + {24'd0, cur_byte};
      part <= '0;
    end else if (cmd.mod_step) begin
      rwork <= {rwork[30:0], 1'b0};
      if (!diff[11]) begin
        part <= diff[10:0];
      end else begin
        part <= {part[9:0], rwork[31]};
      end
    end
  end

  assign stat.mod_last = (mod_cnt == 6'd31);
  assign bkt = part[phbs_pkg::BucketBits-1:0];

  // After reset the fill store is zeroed one bucket per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign stat.clear_last =
    (clr_addr == phbs_pkg::BucketBits'(phbs_pkg::MaxBuckets - 1));

  assign fill_addr = cmd.clear_step ? clr_addr : bkt;
  assign fill_we = cmd.clear_step | cmd.fill_write;
  assign fill_wdata = cmd.clear_step ? '0 : fill + 1'b1;

  phbs_ram #(.Width(phbs_pkg::FillBits), .Depth(phbs_pkg::MaxBuckets)) u_fill (
    .clk(clk), .we(fill_we), .addr(fill_addr),
    .wdata(fill_wdata), .rdata(fill_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_rd_pending <= 1'b0;
    end else begin
      fill_rd_pending <= cmd.fill_read;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_rd_pending) begin
      fill <= fill_rdata;
    end
  end

  assign stat.is_search = is_search;
  assign stat.bucket_full = (fill >= phbs_pkg::FillBits'(phbs_pkg::SlotsPerBucket));

  logic [phbs_pkg::SlotAddrBits-1:0] slot_addr;
  logic [phbs_pkg::SlotAddrBits-1:0] slot_sel;
  logic [phbs_pkg::WordAddrBits-1:0] word_addr;
  logic [63:0] word_rdata;
  logic [4:0]  len_rdata;
  logic [63:0] key_word;

  assign slot_sel = is_search ? {bkt, slot_idx[phbs_pkg::SlotBits-1:0]}
                              : {bkt, fill[phbs_pkg::SlotBits-1:0]};
  assign slot_addr = slot_sel;
  assign word_addr = phbs_pkg::WordAddrBits'(slot_sel * phbs_pkg::KeyWords + word_idx);
  assign key_word = key[64*word_idx +: 64];

  phbs_ram #(.Width(64), .Depth(phbs_pkg::TotalWords)) u_words (
    .clk(clk), .we(cmd.key_write), .addr(word_addr),
    .wdata(key_word), .rdata(word_rdata)
  );

  phbs_ram #(.Width(5), .Depth(phbs_pkg::TotalSlots)) u_lens (
    .clk(clk), .we(cmd.key_write && word_idx == '0), .addr(slot_addr),
    .wdata(5'(len)), .rdata(len_rdata)
  );

  assign stat.word_last = (word_idx == phbs_pkg::WordSelBits'(phbs_pkg::KeyWords - 1));
  assign stat.slot_last = (slot_idx == fill);

  // Compare runs word by word; a match on the last word ends the search at once.
  logic cmp_word_last;
  assign cmp_word_last = stat.word_last;
  assign word_ok = (word_rdata == key_word) && (len_rdata == 5'(len));
  assign stat.matched = word_ok && cmp_word_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_idx <= '0;
      word_idx <= '0;
      matched <= 1'b0;
    end else if (cmd.key_write) begin
      word_idx <= word_idx + 1'b1;
    end else if (cmd.slot_compare) begin
      if (!word_ok) begin
        slot_idx <= slot_idx + 1'b1;
        word_idx <= '0;
      end else if (cmp_word_last) begin
        matched <= 1'b1;
      end else begin
        word_idx <= word_idx + 1'b1;
      end
    end
  end

  always_comb begin
    if (is_search) begin
      status_reg = matched ? phbs_pkg::StatusHit : phbs_pkg::StatusMiss;
    end else begin
      status_reg = stat.bucket_full ? phbs_pkg::StatusFull : phbs_pkg::StatusInserted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_reg <= 1'b0;
    end else begin
      done_reg <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status <= status_reg;
      bucket <= 10'(bkt);
    end
  end

  assign done = done_reg;
endmodule

[sv/polynomial_hash_bucket_set_top.sv]
// Top level of the polynomial hash bucket set.
//  channel   signals                                          direction
//  config    cfg_we, cfg_index, cfg_data                      in
//  request   start, busy, kind, key_bytes_low/mid/high, key_length  in, busy out
//  result    done, status, bucket                             out
// A request keeps busy high through the hash steps, one per key byte, the modulo
// steps, the fill read and its wait state, a decision state and a done state, plus
// the key word writes for an insert or a read and compare per word for a search.
// The sequential Horner multiply and the one-bit-per-cycle modulo set the rate.
// Reset starts a pass that zeroes the bucket fill counts; busy is high.
// done is high for a single cycle, the first in which busy is low; the receiver cannot stall it.
module polynomial_hash_bucket_set_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [63:0] key_bytes_low,
  input  logic [63:0] key_bytes_mid,
  input  logic [31:0] key_bytes_high,
  input  logic [4:0]  key_length,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  bucket
);
  phbs_pkg::phbs_cmd_t  cmd;
  phbs_pkg::phbs_stat_t stat;

  phbs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .busy(busy), .cmd(cmd)
  );

  phbs_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .kind(kind), .key_bytes_low(key_bytes_low),
    .key_bytes_mid(key_bytes_mid), .key_bytes_high(key_bytes_high),
    .key_length(key_length), .cmd(cmd), .stat(stat), .done(done),
    .status(status), .bucket(bucket)
  );
endmodule
